// File: rtl/tra_pkg.sv
// Shared types and codes for the touch report assembler.
package tra_pkg;

    localparam int CFG_IDX_W = 4;

    localparam logic [4:0] EVT_SYN = 5'd0;
    localparam logic [4:0] EVT_KEY = 5'd1;
    localparam logic [4:0] EVT_ABS = 5'd3;

    localparam logic [9:0] CODE_X        = 10'd0;
    localparam logic [9:0] CODE_Y        = 10'd1;
    localparam logic [9:0] CODE_PRESSURE = 10'd24;
    localparam logic [9:0] CODE_TOUCH    = 10'd330;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_DOWN = 2'd1;
    localparam logic [1:0] ST_UP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_SIZE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECT_ENABLE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_XMAP_FROM_X    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_XMAP_FROM_Y    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_XMAP_OFFSET    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YMAP_FROM_X    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_YMAP_FROM_Y    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_YMAP_OFFSET    = 4'd7;

    typedef struct packed {
        logic [4:0]         ev_type;
        logic [9:0]         ev_code;
        logic signed [15:0] ev_value;
    } ev_t;

    typedef struct packed {
        logic [1:0]         rpt_state;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pressure;
    } rpt_t;

    typedef struct packed {
        logic [15:0]        screen_size;
        logic               correct_enable;
        logic signed [31:0] xmap_from_x;
        logic signed [31:0] xmap_from_y;
        logic signed [31:0] xmap_offset;
        logic signed [31:0] ymap_from_x;
        logic signed [31:0] ymap_from_y;
        logic signed [31:0] ymap_offset;
    } cfg_t;

    // one report request passed from the event decoder to the report pipeline
    typedef struct packed {
        logic [1:0]         pkt_state;
        logic               x_upd;
        logic               y_upd;
        logic signed [17:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] pressure;
    } job_t;

endpackage

// File: rtl/tra_front.sv
// Event decoder: tracks packet state and issues a report request on sync.
module tra_front (
    input  logic               clk,
    input  logic               rst_n,
    input  tra_pkg::cfg_t      cfg,
    input  logic               ev_valid,
    output logic               ev_ready,
    input  tra_pkg::ev_t       ev,
    input  logic               q_full,
    output logic               q_push,
    output tra_pkg::job_t      q_data
);

    logic [1:0]         pending_state_reg, pending_state_next;
    logic               x_seen_reg, x_seen_next;
    logic               y_seen_reg, y_seen_next;
    logic signed [17:0] raw_x_reg, raw_x_next;
    logic signed [15:0] raw_y_reg, raw_y_next;
    logic signed [15:0] held_pressure_reg, held_pressure_next;
    logic               accept;
    logic               is_sync;

    assign ev_ready = !q_full;
    assign accept   = ev_valid && ev_ready;
    assign is_sync  = (ev.ev_type == tra_pkg::EVT_SYN);
    assign q_push   = accept && is_sync;

    always_comb
    begin
        q_data.pkt_state = pending_state_reg;
        q_data.x_upd     = x_seen_reg && (pending_state_reg != tra_pkg::ST_UP);
        q_data.y_upd     = y_seen_reg && (pending_state_reg != tra_pkg::ST_UP);
        q_data.raw_x     = raw_x_reg;
        q_data.raw_y     = raw_y_reg;
        q_data.pressure  = held_pressure_reg;
    end

    always_comb
    begin
        pending_state_next = pending_state_reg;
        x_seen_next        = x_seen_reg;
        y_seen_next        = y_seen_reg;
        raw_x_next         = raw_x_reg;
        raw_y_next         = raw_y_reg;
        held_pressure_next = held_pressure_reg;
        if (accept)
        begin
            unique case (ev.ev_type)
                tra_pkg::EVT_KEY:
                begin
                    if (ev.ev_code == tra_pkg::CODE_TOUCH)
                        pending_state_next = (ev.ev_value != 16'sd0) ? tra_pkg::ST_DOWN
                                                                      : tra_pkg::ST_UP;
                end
                tra_pkg::EVT_ABS:
                begin
                    if (ev.ev_code == tra_pkg::CODE_X)
                    begin
                        // mirrored axis: full scale minus reading
                        raw_x_next  = $signed({2'b00, cfg.screen_size})
                                    - $signed({{2{ev.ev_value[15]}}, ev.ev_value});
                        x_seen_next = 1'b1;
                    end
                    else if (ev.ev_code == tra_pkg::CODE_Y)
                    begin
                        raw_y_next  = ev.ev_value;
                        y_seen_next = 1'b1;
                    end
                    else if (ev.ev_code == tra_pkg::CODE_PRESSURE)
                        held_pressure_next = ev.ev_value;
                end
                tra_pkg::EVT_SYN:
                begin
                    pending_state_next = tra_pkg::ST_NONE;
                    x_seen_next        = 1'b0;
                    y_seen_next        = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_state_reg <= tra_pkg::ST_NONE;
            x_seen_reg        <= 1'b0;
            y_seen_reg        <= 1'b0;
            raw_x_reg         <= '0;
            raw_y_reg         <= '0;
            held_pressure_reg <= '0;
        end
        else
        begin
            pending_state_reg <= pending_state_next;
            x_seen_reg        <= x_seen_next;
            y_seen_reg        <= y_seen_next;
            raw_x_reg         <= raw_x_next;
            raw_y_reg         <= raw_y_next;
            held_pressure_reg <= held_pressure_next;
        end
    end

`ifndef ASSERT_OFF
    a_sync_clears: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (pending_state_reg == tra_pkg::ST_NONE) && !x_seen_reg && !y_seen_reg)
        else $error("packet state not cleared after sync");
`endif

endmodule

// File: rtl/tra_fifo.sv
// Small request queue between the event decoder and the report pipeline.
module tra_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tra_pkg::job_t wr_data,
    output logic          full,
    input  logic          pop,
    output tra_pkg::job_t rd_data,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tra_pkg::job_t    mem [DEPTH];
    tra_pkg::job_t    rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = rd_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
        // head is prefetched into a register from the next read pointer; a request landing on the new head bypasses
        if (do_push && (wr_ptr_reg == rd_ptr_next))
            rd_data_reg <= wr_data;
        else
            rd_data_reg <= mem[rd_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not rise on push");
    a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not fall on pop");
`endif

endmodule

// File: rtl/tra_back.sv
// Report pipeline: affine products, sum and saturate, held position, output register.
module tra_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tra_pkg::cfg_t cfg,
    input  logic          q_empty,
    output logic          q_pop,
    input  tra_pkg::job_t q_data,
    output logic          rpt_valid,
    input  logic          rpt_ready,
    output tra_pkg::rpt_t rpt
);

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        logic signed [15:0] r;
        if (v > 36'sd32767)
            r = 16'sh7fff;
        else if (v < -36'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // stage 1: products and pass-through values
    logic               s1_valid_reg;
    logic [1:0]         s1_state_reg;
    logic               s1_x_upd_reg, s1_y_upd_reg;
    logic signed [15:0] s1_pressure_reg;
    logic signed [15:0] s1_px_reg, s1_py_reg;
    logic signed [49:0] s1_xx_reg, s1_yx_reg;
    logic signed [47:0] s1_xy_reg, s1_yy_reg;

    logic               out_valid_reg;
    tra_pkg::rpt_t      out_reg;
    logic signed [15:0] held_x_reg, held_x_next;
    logic signed [15:0] held_y_reg, held_y_next;

    logic               out_free, s1_move, s1_load;
    logic signed [51:0] sum_x, sum_y;
    logic signed [15:0] cx, cy;

    assign out_free = !out_valid_reg || rpt_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_load  = !s1_valid_reg || s1_move;
    assign q_pop    = s1_load && !q_empty;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_state_reg    <= q_data.pkt_state;
            s1_x_upd_reg    <= q_data.x_upd;
            s1_y_upd_reg    <= q_data.y_upd;
            s1_pressure_reg <= q_data.pressure;
            s1_px_reg       <= sat16({{18{q_data.raw_x[17]}}, q_data.raw_x});
            s1_py_reg       <= q_data.raw_y;
            s1_xx_reg       <= cfg.xmap_from_x * q_data.raw_x;
            s1_xy_reg       <= cfg.xmap_from_y * q_data.raw_y;
            s1_yx_reg       <= cfg.ymap_from_x * q_data.raw_x;
            s1_yy_reg       <= cfg.ymap_from_y * q_data.raw_y;
        end
    end

    // stage 2: Q16.16 sum, floor by arithmetic shift, saturate
    always_comb
    begin
        sum_x = $signed({{2{s1_xx_reg[49]}}, s1_xx_reg})
              + $signed({{4{s1_xy_reg[47]}}, s1_xy_reg})
              + $signed({{20{cfg.xmap_offset[31]}}, cfg.xmap_offset});
        sum_y = $signed({{2{s1_yx_reg[49]}}, s1_yx_reg})
              + $signed({{4{s1_yy_reg[47]}}, s1_yy_reg})
              + $signed({{20{cfg.ymap_offset[31]}}, cfg.ymap_offset});
        cx = sat16(sum_x[51:16]);
        cy = sat16(sum_y[51:16]);
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        if (s1_x_upd_reg)
            held_x_next = cfg.correct_enable ? cx : s1_px_reg;
        if (s1_y_upd_reg)
            held_y_next = cfg.correct_enable ? cy : s1_py_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_reg.rpt_state <= s1_state_reg;
            out_reg.pos_x     <= held_x_next;
            out_reg.pos_y     <= held_y_next;
            out_reg.pressure  <= s1_pressure_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= !q_empty;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (s1_move)
            begin
                held_x_reg <= held_x_next;
                held_y_reg <= held_y_next;
            end
        end
    end

    assign rpt_valid = out_valid_reg;
    assign rpt       = out_reg;

`ifndef ASSERT_OFF
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("product stage dropped a request while output stalled");
`endif

endmodule

// File: rtl/touch_report_assembler.sv
// Touch report assembler top level: config registers, decoder, queue and report pipeline.
// Path: a sync event's request goes through the queue, the stage 1 register and the output register to rpt.
// Throughput: one event per cycle while the queue is not full; one report per cycle while
// rpt_ready allows, limited by the queue push and the two-stage multiply/saturate pipeline behind it.
// Reset: rst_n asynchronous active low; clears packet state, held values, queue and
// pipeline, and loads the register defaults.
module touch_report_assembler #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           ev_valid,
    output logic                           ev_ready,
    input  tra_pkg::ev_t                   ev,
    output logic                           rpt_valid,
    input  logic                           rpt_ready,
    output tra_pkg::rpt_t                  rpt,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    tra_pkg::cfg_t cfg_reg;
    tra_pkg::job_t push_data, pop_data;
    logic          q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_size    <= 16'd4096;
            cfg_reg.correct_enable <= 1'b0;
            cfg_reg.xmap_from_x    <= 32'sd65536;
            cfg_reg.xmap_from_y    <= '0;
            cfg_reg.xmap_offset    <= '0;
            cfg_reg.ymap_from_x    <= '0;
            cfg_reg.ymap_from_y    <= 32'sd65536;
            cfg_reg.ymap_offset    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tra_pkg::REG_SCREEN_SIZE:    cfg_reg.screen_size    <= cfg_data[15:0];
                tra_pkg::REG_CORRECT_ENABLE: cfg_reg.correct_enable <= cfg_data[0];
                tra_pkg::REG_XMAP_FROM_X:    cfg_reg.xmap_from_x    <= cfg_data;
                tra_pkg::REG_XMAP_FROM_Y:    cfg_reg.xmap_from_y    <= cfg_data;
                tra_pkg::REG_XMAP_OFFSET:    cfg_reg.xmap_offset    <= cfg_data;
                tra_pkg::REG_YMAP_FROM_X:    cfg_reg.ymap_from_x    <= cfg_data;
                tra_pkg::REG_YMAP_FROM_Y:    cfg_reg.ymap_from_y    <= cfg_data;
                tra_pkg::REG_YMAP_OFFSET:    cfg_reg.ymap_offset    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tra_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev       (ev),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    tra_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (pop_data),
        .empty   (q_empty)
    );

    tra_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (pop_data),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt)
    );

endmodule
